// File: rtl/core/nmt_pkg.sv
// Shared types, constants and helper functions for the NAT mapping table.
package nmt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int ADDR_W        = 4;

    // operation codes
    localparam logic [1:0] OP_LOOKUP_EXT = 2'd0;
    localparam logic [1:0] OP_LOOKUP_INT = 2'd1;
    localparam logic [1:0] OP_INSERT     = 2'd2;
    localparam logic [1:0] OP_TICK       = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_TICK_DONE = 2'd3;

    // register indexes
    localparam logic [1:0] REG_ICMP_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_TCP_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_PORT_SEED    = 2'd2;

    localparam logic [15:0] PORT_SPAN  = 16'd64511;
    localparam logic [15:0] PORT_BASE  = 16'd1025;
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;
    localparam logic [15:0] SEED_RESET = 16'd1;

    typedef struct packed {
        logic [15:0] icmp_timeout;
        logic [15:0] tcp_timeout;
    } nmt_cfg_t;

    typedef struct packed {
        logic load_in;
        logic match;
        logic pick;
        logic sweep_start;
        logic sweep_step;
        logic out_load;
    } nmt_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic out_free;
    } nmt_sts_t;

    function automatic logic [15:0] lfsr_step(input logic [15:0] v);
        logic [15:0] r;
        r = {1'b0, v[15:1]};
        if (v[0]) begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

    // v below twice the span: one compare and subtract gives the remainder
    function automatic logic [15:0] port_of(input logic [15:0] v);
        logic [15:0] r;
        r = (v >= PORT_SPAN) ? (v - PORT_SPAN) : v;
        return r + PORT_BASE;
    endfunction

endpackage

// File: rtl/core/nmt_regs.sv
// Configuration register file with an APB-style access port.
module nmt_regs import nmt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output nmt_cfg_t          cfg,
    output logic              seed_load,
    output logic [15:0]       lfsr_seed
);

    logic [15:0] icmp_reg;
    logic [15:0] tcp_reg;
    logic [15:0] seed_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            icmp_reg <= 16'd60;
            tcp_reg  <= 16'd300;
            seed_reg <= SEED_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ICMP_TIMEOUT: icmp_reg <= pwdata[15:0];
                REG_TCP_TIMEOUT:  tcp_reg  <= pwdata[15:0];
                REG_PORT_SEED:    seed_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ICMP_TIMEOUT: prdata = {16'd0, icmp_reg};
            REG_TCP_TIMEOUT:  prdata = {16'd0, tcp_reg};
            REG_PORT_SEED:    prdata = {16'd0, seed_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // a zero seed would lock the generator: load one instead
    assign seed_load = wr_en && (reg_idx == REG_PORT_SEED);
    assign lfsr_seed = (pwdata[15:0] == 16'd0) ? SEED_RESET : pwdata[15:0];

    assign cfg.icmp_timeout = icmp_reg;
    assign cfg.tcp_timeout  = tcp_reg;

endmodule

// File: rtl/core/nmt_ctrl.sv
// Controller state machine that sequences lookup, insert and aging sweeps.
module nmt_ctrl import nmt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [1:0] in_op,
    output logic       s_tready,
    input  nmt_sts_t   sts,
    output nmt_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MATCH  = 3'd1;
    localparam logic [2:0] S_PICK   = 3'd2;
    localparam logic [2:0] S_SWEEP  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                // hold the slave side closed while reset is asserted
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load_in = 1'b1;
                    if (in_op == OP_TICK) begin
                        cmd.sweep_start = 1'b1;
                        state_next      = S_SWEEP;
                    end else begin
                        state_next = S_MATCH;
                    end
                end
            end
            S_MATCH: begin
                cmd.match  = 1'b1;
                state_next = S_PICK;
            end
            S_PICK: begin
                cmd.pick   = 1'b1;
                state_next = S_RESULT;
            end
            S_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/nmt_dp.sv
// Datapath: slot cells, stamp memory, port generator, seconds counter, result register.
module nmt_dp import nmt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  nmt_cmd_t    cmd,
    output nmt_sts_t    sts,
    input  nmt_cfg_t    cfg,
    input  logic        seed_load,
    input  logic [15:0] lfsr_seed,
    input  logic [1:0]  in_op,
    input  logic        in_kind,
    input  logic [31:0] in_inner_address,
    input  logic [15:0] in_inner_port,
    input  logic [15:0] in_outer_port,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_status,
    output logic        out_kind,
    output logic [31:0] out_inner_address,
    output logic [15:0] out_inner_port,
    output logic [15:0] out_outer_port
);

    // latched request
    logic [1:0]  op_reg;
    logic        kind_reg;
    logic [31:0] iaddr_reg;
    logic [15:0] iport_reg;
    logic [15:0] oport_reg;

    // slot cells
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                     slot_kind_reg  [TABLE_ENTRIES];
    logic [31:0]              slot_iaddr_reg [TABLE_ENTRIES];
    logic [15:0]              slot_iport_reg [TABLE_ENTRIES];
    logic [15:0]              slot_oport_reg [TABLE_ENTRIES];

    // kind and insertion second per slot, read only by the aging sweep
    logic [32:0] stamp_mem [TABLE_ENTRIES];
    logic [32:0] stamp_q_reg;

    logic [TABLE_ENTRIES-1:0] hit_reg;
    logic [TABLE_ENTRIES-1:0] hit_next;
    logic [TABLE_ENTRIES-1:0] sel_reg;
    logic [TABLE_ENTRIES-1:0] low_hit;
    logic                     found_reg;
    logic                     any_hit;
    logic [IDX_W-1:0]         low_idx;
    logic                     ins_ok;

    logic [15:0] lfsr_reg;
    logic [15:0] lfsr_adv;
    logic [15:0] new_port;
    logic [31:0] now_reg;

    logic [CNT_W-1:0] cnt_reg;
    logic             issue;
    logic             chk_valid_reg;
    logic [IDX_W-1:0] chk_idx_reg;
    logic [31:0]      age;
    logic [31:0]      limit;
    logic             expire;

    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic        out_kind_reg;
    logic [31:0] out_iaddr_reg;
    logic [15:0] out_iport_reg;
    logic [15:0] out_oport_reg;
    logic        res_kind;
    logic [31:0] res_iaddr;
    logic [15:0] res_iport;
    logic [15:0] res_oport;
    logic [1:0]  res_status;
    logic        res_show;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg    <= in_op;
            kind_reg  <= in_kind;
            iaddr_reg <= in_inner_address;
            iport_reg <= in_inner_port;
            oport_reg <= in_outer_port;
        end
    end

    // compare every cell in place
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (op_reg == OP_INSERT) begin
                hit_next[i] = !valid_reg[i];
            end else if (op_reg == OP_LOOKUP_EXT) begin
                hit_next[i] = valid_reg[i] && (slot_kind_reg[i] == kind_reg)
                              && (slot_oport_reg[i] == oport_reg);
            end else begin
                hit_next[i] = valid_reg[i] && (slot_kind_reg[i] == kind_reg)
                              && (slot_iaddr_reg[i] == iaddr_reg)
                              && (slot_iport_reg[i] == iport_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.match) begin
            hit_reg <= hit_next;
        end
    end

    // lowest set bit, and its index
    assign low_hit = hit_reg & (~hit_reg + TABLE_ENTRIES'(1));
    assign any_hit = |hit_reg;
    assign ins_ok  = cmd.pick && any_hit && (op_reg == OP_INSERT);

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (low_hit[i]) begin
                low_idx = low_idx | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pick) begin
            sel_reg   <= low_hit;
            found_reg <= any_hit;
        end
    end

    assign lfsr_adv = lfsr_step(lfsr_reg);
    assign new_port = port_of(lfsr_adv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg <= SEED_RESET;
        end else if (seed_load) begin
            lfsr_reg <= lfsr_seed;
        end else if (ins_ok) begin
            lfsr_reg <= lfsr_adv;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (ins_ok && low_hit[i]) begin
                slot_kind_reg[i]  <= kind_reg;
                slot_iaddr_reg[i] <= iaddr_reg;
                slot_iport_reg[i] <= iport_reg;
                slot_oport_reg[i] <= new_port;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ins_ok) begin
            stamp_mem[low_idx] <= {kind_reg, now_reg};
        end
        if (issue) begin
            stamp_q_reg <= stamp_mem[cnt_reg[IDX_W-1:0]];
        end
    end

    // aging sweep: read one stamp per cycle, check it the cycle after
    assign issue = cmd.sweep_step && (cnt_reg < CNT_W'(TABLE_ENTRIES));
    assign sts.sweep_last = (cnt_reg == CNT_W'(TABLE_ENTRIES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg       <= '0;
            cnt_reg       <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            if (cmd.sweep_start) begin
                now_reg <= now_reg + 32'd1;
                cnt_reg <= '0;
            end else if (cmd.sweep_step) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            chk_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            chk_idx_reg <= cnt_reg[IDX_W-1:0];
        end
    end

    assign age    = now_reg - stamp_q_reg[31:0];
    assign limit  = stamp_q_reg[32] ? {16'd0, cfg.tcp_timeout} : {16'd0, cfg.icmp_timeout};
    assign expire = chk_valid_reg && valid_reg[chk_idx_reg] && (age > limit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (ins_ok) begin
                valid_reg <= valid_reg | low_hit;
            end
            if (expire) begin
                valid_reg[chk_idx_reg] <= 1'b0;
            end
        end
    end

    // gather the selected slot
    always_comb begin
        res_kind  = 1'b0;
        res_iaddr = '0;
        res_iport = '0;
        res_oport = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (sel_reg[i]) begin
                res_kind  = res_kind | slot_kind_reg[i];
                res_iaddr = res_iaddr | slot_iaddr_reg[i];
                res_iport = res_iport | slot_iport_reg[i];
                res_oport = res_oport | slot_oport_reg[i];
            end
        end
    end

    always_comb begin
        res_show = 1'b0;
        priority if (op_reg == OP_TICK) begin
            res_status = ST_TICK_DONE;
        end else if (found_reg) begin
            res_status = ST_OK;
            res_show   = 1'b1;
        end else if (op_reg == OP_INSERT) begin
            res_status = ST_FULL;
        end else begin
            res_status = ST_NOT_FOUND;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg <= res_status;
            out_kind_reg   <= res_show && res_kind;
            out_iaddr_reg  <= res_show ? res_iaddr : 32'd0;
            out_iport_reg  <= res_show ? res_iport : 16'd0;
            out_oport_reg  <= res_show ? res_oport : 16'd0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_status        = out_status_reg;
    assign out_kind          = out_kind_reg;
    assign out_inner_address = out_iaddr_reg;
    assign out_inner_port    = out_iport_reg;
    assign out_outer_port    = out_oport_reg;

endmodule

// File: rtl/core/nat_mapping_table_top.sv
// Top level of the NAT mapping table: register port, controller and datapath.
// Flow: a lookup or insert word passes the match, pick and result states before it shows on
//   the master side; a tick word passes the sweep over every slot and the result state.
// One word in flight: a new word is taken once the last result is loaded for the master side;
//   the aging sweep reads one slot stamp per cycle through the single stamp memory port.
// Reset: synchronous, active low; clears all slot valid bits, the seconds counter and
//   the output valid flag, and restores timeouts 60/300 s and a port generator seed of one.
module nat_mapping_table_top import nmt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,   // inner_address[31:0], inner_port[47:32], outer_port[63:48]
    input  logic [2:0]        s_tuser,   // op[1:0], entry_kind[2]
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,   // out_inner_address[31:0], out_inner_port[47:32],
                                         // out_outer_port[63:48]
    output logic [2:0]        m_tuser,   // status[1:0], out_kind[2]
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    nmt_cfg_t    cfg;
    nmt_cmd_t    cmd;
    nmt_sts_t    sts;
    logic        seed_load;
    logic [15:0] lfsr_seed;
    logic [1:0]  out_status;
    logic        out_kind;

    // timeouts and generator seed
    nmt_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .seed_load (seed_load),
        .lfsr_seed (lfsr_seed)
    );

    // one word at a time: accept, then compare, pick and hand over, or for a tick sweep and hand over
    nmt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_op    (s_tuser[1:0]),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // slots, aging and the output register that parts the two streams
    nmt_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .cfg               (cfg),
        .seed_load         (seed_load),
        .lfsr_seed         (lfsr_seed),
        .in_op             (s_tuser[1:0]),
        .in_kind           (s_tuser[2]),
        .in_inner_address  (s_tdata[31:0]),
        .in_inner_port     (s_tdata[47:32]),
        .in_outer_port     (s_tdata[63:48]),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_status        (out_status),
        .out_kind          (out_kind),
        .out_inner_address (m_tdata[31:0]),
        .out_inner_port    (m_tdata[47:32]),
        .out_outer_port    (m_tdata[63:48])
    );

    assign m_tuser = {out_kind, out_status};

`ifndef SYNTHESIS
    // one word in flight: after an accept the slave side closes
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a word is in flight");

    // never overwrite a result the sink has not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result register overwritten");

    // only a found or inserted status carries entry fields
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] != ST_OK)) |-> ((m_tdata == 64'd0) && !m_tuser[2]))
        else $error("entry fields on a miss, full or tick word");

    // a new port lies in the dynamic range
    a_port_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] == ST_OK)) |-> (m_tdata[63:48] >= PORT_BASE))
        else $error("external port below the dynamic range");
`endif

endmodule

// File: tb/tb_nat_mapping_table_top.sv
// Self-checking testbench for the NAT mapping table: streams lookups, inserts and ticks.
module tb_nat_mapping_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nmt_pkg::*;

    // Slow correct runs stay far below this limit.
    localparam int CYCLE_LIMIT = 600000;
    // Drain time after the last word: one full aging sweep plus margin.
    localparam int DRAIN_CYCLES = TABLE_ENTRIES + 16;

    localparam logic KIND_ICMP = 1'b0;
    localparam logic KIND_TCP  = 1'b1;
    // Register index with no register behind it.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic        kind;
        logic [31:0] addr;
        logic [15:0] iport;
        logic [15:0] oport;
    } nat_word_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata = '0;    // inner_address[31:0], inner_port[47:32], outer_port[63:48]
    logic [2:0]        s_tuser = '0;    // op[1:0], entry_kind[2]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [63:0]       m_tdata;         // out_inner_address[31:0], out_inner_port[47:32],
                                        // out_outer_port[63:48]
    logic [2:0]        m_tuser;         // status[1:0], out_kind[2]
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Shadow copy of the translation table and its registers.
    logic        tbl_valid [TABLE_ENTRIES];
    logic        tbl_kind  [TABLE_ENTRIES];
    logic [31:0] tbl_addr  [TABLE_ENTRIES];
    logic [15:0] tbl_iport [TABLE_ENTRIES];
    logic [15:0] tbl_oport [TABLE_ENTRIES];
    logic [31:0] tbl_stamp [TABLE_ENTRIES];
    logic [31:0] now_sec = '0;
    logic [15:0] gen_state = SEED_RESET;
    logic [15:0] icmp_limit = 16'd60;
    logic [15:0] tcp_limit = 16'd300;

    nat_word_t pending_words[$];
    int        mismatch_count = 0;
    int        full_events = 0;
    int        cycle_count = 0;
    int        sender_idle_pct = 0;
    int        receiver_stall_pct = 0;

    nat_mapping_table_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        foreach (tbl_valid[i]) begin
            tbl_valid[i] = 1'b0;
        end
    end

    // Hold off the result side at random; a zero percentage gives an unbroken stretch.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Work out the result word of one accepted request and advance the shadow table.
    function automatic nat_word_t nat_predict(input logic [1:0] op, input logic kind,
                                              input logic [31:0] addr, input logic [15:0] iport,
                                              input logic [15:0] oport);
        nat_word_t   w;
        int          hit;
        logic [31:0] age;
        w = '0;
        w.status = ST_NOT_FOUND;
        hit = -1;
        case (op)
            OP_LOOKUP_EXT: begin
                // scan downward so the lowest matching slot is the one kept
                for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
                    if (tbl_valid[i] && tbl_kind[i] == kind && tbl_oport[i] == oport) begin
                        hit = i;
                    end
                end
            end
            OP_LOOKUP_INT: begin
                for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
                    if (tbl_valid[i] && tbl_kind[i] == kind && tbl_addr[i] == addr &&
                        tbl_iport[i] == iport) begin
                        hit = i;
                    end
                end
            end
            OP_INSERT: begin
                for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
                    if (!tbl_valid[i]) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    // full table: no change, generator holds
                    w.status = ST_FULL;
                    full_events++;
                end else begin
                    gen_state = {1'b0, gen_state[15:1]} ^ (gen_state[0] ? LFSR_TAPS : 16'h0000);
                    tbl_valid[hit] = 1'b1;
                    tbl_kind[hit]  = kind;
                    tbl_addr[hit]  = addr;
                    tbl_iport[hit] = iport;
                    tbl_oport[hit] = 16'((32'(gen_state) % 32'(PORT_SPAN)) + 32'(PORT_BASE));
                    tbl_stamp[hit] = now_sec;
                end
            end
            default: begin
                // advance the clock first, then age against it; ages wrap mod 2^32
                now_sec = now_sec + 32'd1;
                foreach (tbl_valid[i]) begin
                    if (tbl_valid[i]) begin
                        age = now_sec - tbl_stamp[i];
                        if (age > {16'h0000, (tbl_kind[i] == KIND_TCP) ? tcp_limit : icmp_limit}) begin
                            tbl_valid[i] = 1'b0;
                        end
                    end
                end
                w.status = ST_TICK_DONE;
            end
        endcase
        if (hit >= 0 && w.status != ST_FULL) begin
            w.status = ST_OK;
            w.kind   = tbl_kind[hit];
            w.addr   = tbl_addr[hit];
            w.iport  = tbl_iport[hit];
            w.oport  = tbl_oport[hit];
        end
        return w;
    endfunction

    function automatic int random_valid_slot();
        int n;
        int pick;
        n = 0;
        foreach (tbl_valid[i]) begin
            if (tbl_valid[i]) begin
                n++;
            end
        end
        if (n == 0) begin
            return -1;
        end
        pick = $urandom_range(n - 1);
        foreach (tbl_valid[i]) begin
            if (tbl_valid[i]) begin
                if (pick == 0) begin
                    return i;
                end
                pick--;
            end
        end
        return -1;
    endfunction

    // Send one request word, with a random idle gap ahead of it, and record its result.
    task automatic send_item(input logic [1:0] op, input logic kind, input logic [31:0] addr,
                             input logic [15:0] iport, input logic [15:0] oport);
        int gap;
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct) begin
            // mostly short gaps, now and then a longer one that can outlast an aging sweep
            gap = ($urandom_range(9) == 0) ? $urandom_range(4, 80) : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {oport, iport, addr};
        s_tuser  <= {kind, op};
        do @(posedge aclk); while (!s_tready);
        pending_words.push_back(nat_predict(op, kind, addr, iport, oport));
    endtask

    // Draw a random request; most lookups and some inserts reuse a live key.
    task automatic send_random_item(input int insert_pct, input int tick_pct);
        int          roll;
        int          slot;
        logic [1:0]  op;
        logic        kind;
        logic [31:0] addr;
        logic [15:0] iport;
        logic [15:0] oport;
        roll  = $urandom_range(99);
        kind  = 1'($urandom);
        addr  = $urandom;
        iport = 16'($urandom);
        oport = 16'($urandom);
        if (roll < insert_pct) begin
            op = OP_INSERT;
        end else if (roll < insert_pct + tick_pct) begin
            op = OP_TICK;
        end else begin
            op = roll[0] ? OP_LOOKUP_INT : OP_LOOKUP_EXT;
        end
        slot = random_valid_slot();
        if (slot >= 0 && $urandom_range(99) < ((op == OP_INSERT) ? 20 : 75)) begin
            // flip the kind now and then so a key matches on everything but kind
            kind  = ($urandom_range(7) == 0) ? ~tbl_kind[slot] : tbl_kind[slot];
            addr  = tbl_addr[slot];
            iport = tbl_iport[slot];
            oport = tbl_oport[slot];
        end
        send_item(op, kind, addr, iport, oport);
    endtask

    // Drop valid and wait until every awaited word is back and the block is quiet.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write a register through setup and access cycles; upper data bits are noise.
    task automatic apb_write(input logic [1:0] index, input logic [15:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (index)
            REG_ICMP_TIMEOUT: icmp_limit = value;
            REG_TCP_TIMEOUT:  tcp_limit = value;
            REG_PORT_SEED:    gen_state = (value == 16'h0000) ? 16'h0001 : value;
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare every accepted result word with the oldest awaited one.
    always @(posedge aclk) begin : check_words
        nat_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected result word, tuser %h tdata %h",
                         $time, m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_words.pop_front();
                compare_field("status", want.status, m_tuser[1:0]);
                compare_field("out_kind", want.kind, m_tuser[2]);
                compare_field("out_inner_address", want.addr, m_tdata[31:0]);
                compare_field("out_inner_port", want.iport, m_tdata[47:32]);
                compare_field("out_outer_port", want.oport, m_tdata[63:48]);
            end
        end
    end

    // Lookups at the field extremes on an empty table, plus a tick with nothing to age.
    task automatic test_empty_table();
        send_item(OP_LOOKUP_EXT, KIND_ICMP, 32'h0000_0000, 16'h0000, 16'h0000);
        send_item(OP_LOOKUP_INT, KIND_TCP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_LOOKUP_EXT, KIND_TCP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_TICK, KIND_ICMP, 32'h0000_0000, 16'h0000, 16'h0000);
    endtask

    // Inserts at the extremes, a duplicate key, and lookups that hit, miss on kind,
    // and resolve to the lowest matching slot.
    task automatic test_insert_and_lookup();
        send_item(OP_INSERT, KIND_ICMP, 32'h0000_0000, 16'h0000, 16'hFFFF);
        send_item(OP_INSERT, KIND_TCP, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
        send_item(OP_INSERT, KIND_TCP, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
        send_item(OP_LOOKUP_INT, KIND_TCP, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
        send_item(OP_LOOKUP_INT, KIND_ICMP, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
        send_item(OP_LOOKUP_EXT, KIND_ICMP, 32'h0000_0000, 16'h0000, tbl_oport[0]);
        send_item(OP_LOOKUP_EXT, KIND_TCP, 32'h0000_0000, 16'h0000, tbl_oport[2]);
        send_item(OP_LOOKUP_EXT, KIND_TCP, 32'h5A5A_A5A5, 16'h1234, tbl_oport[0]);
    endtask

    // Short timeouts: ICMP expires on the next tick, TCP after a few; a freed slot is reused.
    task automatic test_aging_and_reuse();
        logic [15:0] old_port;
        settle();
        apb_write(REG_ICMP_TIMEOUT, 16'd0);
        apb_write(REG_TCP_TIMEOUT, 16'd2);
        old_port = tbl_oport[1];
        send_item(OP_TICK, KIND_TCP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_LOOKUP_INT, KIND_ICMP, 32'h0000_0000, 16'h0000, 16'h0000);
        send_item(OP_INSERT, KIND_ICMP, 32'h1234_5678, 16'h8000, 16'h0001);
        send_item(OP_TICK, KIND_ICMP, 32'h0000_0000, 16'h0000, 16'h0000);
        send_item(OP_TICK, KIND_ICMP, 32'h0000_0000, 16'h0000, 16'h0000);
        send_item(OP_TICK, KIND_ICMP, 32'h0000_0000, 16'h0000, 16'h0000);
        send_item(OP_LOOKUP_EXT, KIND_TCP, 32'h0000_0000, 16'h0000, old_port);
    endtask

    // Zero seed falls back to one, the top seed, and a write to the unused index is ignored.
    task automatic test_port_seed();
        settle();
        apb_write(REG_PORT_SEED, 16'h0000);
        send_item(OP_INSERT, KIND_TCP, 32'hC0A8_0001, 16'd80, 16'h0000);
        settle();
        apb_write(REG_PORT_SEED, 16'hFFFF);
        apb_write(REG_UNUSED, 16'hFFFF);
        apb_write(REG_TCP_TIMEOUT, 16'hFFFF);
        send_item(OP_INSERT, KIND_TCP, 32'hC0A8_0002, 16'd443, 16'h0000);
        send_item(OP_LOOKUP_INT, KIND_TCP, 32'hC0A8_0002, 16'd443, 16'h0000);
    endtask

    // Fill the table with timeouts at their maximum until inserts are refused, then
    // drop both timeouts to zero so one tick empties it again.
    task automatic test_table_full();
        int target;
        settle();
        apb_write(REG_ICMP_TIMEOUT, 16'hFFFF);
        apb_write(REG_TCP_TIMEOUT, 16'hFFFF);
        apb_write(REG_PORT_SEED, 16'($urandom_range(1, 65535)));
        sender_idle_pct = 11;
        receiver_stall_pct = 11;
        target = full_events + 5;
        while (full_events < target) begin
            send_random_item(85, 3);
        end
        settle();
        apb_write(REG_ICMP_TIMEOUT, 16'd0);
        apb_write(REG_TCP_TIMEOUT, 16'd0);
        send_item(OP_TICK, KIND_TCP, $urandom, 16'($urandom), 16'($urandom));
        send_item(OP_INSERT, KIND_ICMP, $urandom, 16'($urandom), 16'($urandom));
    endtask

    task automatic run_phase(input logic [15:0] icmp_s, input logic [15:0] tcp_s,
                             input logic [15:0] seed, input int idle_pct,
                             input int stall_pct, input int count);
        // every awaited word must be back before the registers move
        settle();
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        apb_write(REG_ICMP_TIMEOUT, icmp_s);
        apb_write(REG_TCP_TIMEOUT, tcp_s);
        apb_write(REG_PORT_SEED, seed);
        repeat (count) send_random_item(26, 16);
    endtask

    // Random traffic under each idling mix and a spread of timeout and seed settings.
    task automatic test_random_traffic();
        run_phase(16'd2, 16'd5, 16'($urandom_range(1, 65535)), 0, 0, 150);
        run_phase(16'd0, 16'd1, 16'h0000, 69, 0, 150);
        run_phase(16'd4, 16'd0, 16'hFFFF, 0, 69, 150);
        run_phase(16'd1, 16'd8, 16'($urandom_range(1, 65535)), 11, 11, 150);
    endtask

    initial begin
        // hold reset, then release it away from the sampling edge
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_insert_and_lookup();
        test_aging_and_reuse();
        test_port_seed();
        test_table_full();
        test_random_traffic();

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
